FILE: sv/ffa_pkg.sv
// Shared constants, types and helpers of the first-fit free-list allocator.
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int RAM_WORDS = 1024;
  localparam int ADDR_W    = $clog2(RAM_WORDS);
  localparam int LINK_W    = ADDR_W + 1;       // holds the null link value RAM_WORDS
  localparam int STEP_W    = LINK_W;           // walk counter reaches RAM_WORDS
  localparam int WORD_W    = 17;               // stored word width
  localparam int ADJ_W     = WORD_W + 1;       // header + size + 2 without wrap
  localparam int HDR_WORDS = 2;
  localparam int LAST_ADDR = RAM_WORDS - 1;

  localparam int CFG_W     = 11;
  localparam int HEAP_MIN  = 4;
  localparam int ACT_W     = 2;
  localparam int REQ_W     = 10;
  localparam int LOC_W     = 10;
  localparam int PADDR_W   = 10;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(RAM_WORDS);

  // action codes
  localparam logic [ACT_W-1:0] ACT_RESERVE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COALESCE = 2'd2;

  // status codes
  localparam logic STAT_DONE     = 1'b0;
  localparam logic STAT_NO_SPACE = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [REQ_W-1:0] request_size;
    logic [LOC_W-1:0] free_location;
  } ffa_item_t;

  typedef struct packed {
    logic              valid;
    logic              status;
    logic [PADDR_W-1:0] payload_address;
  } ffa_result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ffa_ram_req_t;

  // Stored link word to link value; anything at or past the RAM reads as null.
  function automatic logic [LINK_W-1:0] link_norm(input logic [WORD_W-1:0] v);
    logic [LINK_W-1:0] r;
    if (v >= WORD_W'(RAM_WORDS)) r = NULL_LINK;
    else                         r = v[LINK_W-1:0];
    return r;
  endfunction

endpackage

FILE: sv/ffa_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
`timescale 1ns / 1ps

interface ffa_req_if import ffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [REQ_W-1:0] request_size;
  logic [LOC_W-1:0] free_location;

  modport source (output valid, action, request_size, free_location, input ready);
  modport sink   (input valid, action, request_size, free_location, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [PADDR_W-1:0] payload_address;

  modport source (output valid, status, payload_address, input ready);
  modport sink   (input valid, status, payload_address, output ready);
endinterface

FILE: sv/ffa_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ffa_walker.sv
// Free-list sequencer: reserve, free and coalesce by read-modify-write on the heap RAM.
`timescale 1ns / 1ps

module ffa_walker import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              heap_init,
  input  logic              item_valid,
  output logic              item_ready,
  input  ffa_item_t         item,
  output ffa_ram_req_t      ram_req,
  input  logic [WORD_W-1:0] ram_rdata,
  output ffa_result_t       res,
  input  logic              res_take
);

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_RD_SIZE, S_RD_LINK, S_EVAL,
    S_TAIL_SZ, S_TAIL_LK, S_PREV, S_HDR_SZ, S_HDR_LK,
    S_ADJ_SIZE, S_ADJ_LINK, S_MRG_SZ, S_MRG_LK, S_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [LINK_W-1:0]  free_head_r, free_head_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [LOC_W-1:0]   loc_r, loc_nxt;
  logic [LINK_W-1:0]  total_r, total_nxt;
  logic [LINK_W-1:0]  cur_r, cur_nxt;
  logic [LINK_W-1:0]  prev_r, prev_nxt;
  logic [LINK_W-1:0]  link_r, link_nxt;     // link of cur, or adjacent block address
  logic [LINK_W-1:0]  succ_r, succ_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [WORD_W-1:0]  size_r, size_nxt;
  logic               status_r, status_nxt;
  logic [PADDR_W-1:0] paddr_r, paddr_nxt;

  logic [LINK_W-1:0]  fh_norm;
  logic [LINK_W-1:0]  tail;
  logic [LINK_W-1:0]  rlink;
  logic [LINK_W-1:0]  alink;
  logic [ADJ_W-1:0]   adj;
  logic               steps_out;

  assign fh_norm   = (free_head_r >= NULL_LINK) ? NULL_LINK : free_head_r;
  assign tail      = cur_r + total_r;
  assign rlink     = (cur_r == LINK_W'(LAST_ADDR)) ? NULL_LINK : link_norm(ram_rdata);
  assign alink     = (link_r == LINK_W'(LAST_ADDR)) ? NULL_LINK : link_norm(ram_rdata);
  assign adj       = ADJ_W'(cur_r) + ADJ_W'(size_r) + ADJ_W'(HDR_WORDS);
  assign steps_out = (steps_r == STEP_W'(RAM_WORDS));

  assign item_ready          = (state_r == S_IDLE);
  assign res.valid           = (state_r == S_FINISH);
  assign res.status          = status_r;
  assign res.payload_address = paddr_r;

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    act_nxt       = act_r;
    req_nxt       = req_r;
    loc_nxt       = loc_r;
    total_nxt     = total_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    link_nxt      = link_r;
    succ_nxt      = succ_r;
    steps_nxt     = steps_r;
    size_nxt      = size_r;
    status_nxt    = status_r;
    paddr_nxt     = paddr_r;
    ram_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          act_nxt    = item.action;
          req_nxt    = item.request_size;
          loc_nxt    = item.free_location;
          total_nxt  = LINK_W'(item.request_size) + LINK_W'(HDR_WORDS);
          cur_nxt    = fh_norm;
          prev_nxt   = NULL_LINK;
          steps_nxt  = '0;
          status_nxt = STAT_DONE;
          paddr_nxt  = '0;
          case (item.action)
            ACT_RESERVE: begin
              if (fh_norm == NULL_LINK) begin
                status_nxt = STAT_NO_SPACE;
                state_nxt  = S_FINISH;
              end else begin
                state_nxt = S_RD_SIZE;
              end
            end
            ACT_FREE: begin
              state_nxt = (item.free_location < LOC_W'(HDR_WORDS)) ? S_FINISH : S_FREE;
            end
            ACT_COALESCE: begin
              state_nxt = (fh_norm == NULL_LINK) ? S_FINISH : S_RD_SIZE;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end

      // push onto list head
      S_FREE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(loc_r) - ADDR_W'(1);
        ram_req.wdata = WORD_W'(free_head_r);
        free_head_nxt = LINK_W'(loc_r) - LINK_W'(HDR_WORDS);
        state_nxt     = S_FINISH;
      end

      S_RD_SIZE: begin
        ram_req.raddr = cur_r[ADDR_W-1:0];
        state_nxt     = S_RD_LINK;
      end

      S_RD_LINK: begin
        ram_req.raddr = cur_r[ADDR_W-1:0] + ADDR_W'(1);
        size_nxt      = ram_rdata;
        state_nxt     = S_EVAL;
      end

      S_EVAL: begin
        if (act_r == ACT_RESERVE) begin
          if (size_r < WORD_W'(total_r)) begin
            if (steps_out || rlink == NULL_LINK) begin
              status_nxt = STAT_NO_SPACE;
              state_nxt  = S_FINISH;
            end else begin
              steps_nxt = steps_r + STEP_W'(1);
              prev_nxt  = cur_r;
              cur_nxt   = rlink;
              state_nxt = S_RD_SIZE;
            end
          end else begin
            link_nxt = rlink;
            if (size_r > WORD_W'(total_r)) begin
              state_nxt = S_TAIL_SZ;
            end else begin
              succ_nxt  = rlink;
              state_nxt = S_PREV;
            end
          end
        end else begin
          if (rlink == NULL_LINK || steps_out) begin
            state_nxt = S_FINISH;
          end else begin
            steps_nxt = steps_r + STEP_W'(1);
            if (ADJ_W'(rlink) == adj) begin
              link_nxt  = rlink;
              state_nxt = S_ADJ_SIZE;
            end else begin
              cur_nxt   = rlink;
              state_nxt = S_RD_SIZE;
            end
          end
        end
      end

      // split: tail block takes the remainder
      S_TAIL_SZ: begin
        ram_req.we    = (tail < NULL_LINK);
        ram_req.waddr = tail[ADDR_W-1:0];
        ram_req.wdata = size_r - WORD_W'(total_r);
        succ_nxt      = (tail >= NULL_LINK) ? NULL_LINK : tail;
        state_nxt     = S_TAIL_LK;
      end

      S_TAIL_LK: begin
        ram_req.we    = (tail < LINK_W'(LAST_ADDR));
        ram_req.waddr = tail[ADDR_W-1:0] + ADDR_W'(1);
        ram_req.wdata = WORD_W'(link_r);
        state_nxt     = S_PREV;
      end

      S_PREV: begin
        if (prev_r == NULL_LINK) begin
          free_head_nxt = succ_r;
        end else begin
          ram_req.we    = (prev_r < LINK_W'(LAST_ADDR));
          ram_req.waddr = prev_r[ADDR_W-1:0] + ADDR_W'(1);
          ram_req.wdata = WORD_W'(succ_r);
        end
        state_nxt = S_HDR_SZ;
      end

      S_HDR_SZ: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_r[ADDR_W-1:0];
        ram_req.wdata = WORD_W'(req_r);
        state_nxt     = S_HDR_LK;
      end

      S_HDR_LK: begin
        ram_req.we    = (cur_r < LINK_W'(LAST_ADDR));
        ram_req.waddr = cur_r[ADDR_W-1:0] + ADDR_W'(1);
        ram_req.wdata = WORD_W'(NULL_LINK);
        paddr_nxt     = PADDR_W'(cur_r + LINK_W'(HDR_WORDS));
        state_nxt     = S_FINISH;
      end

      // merge with the block directly after cur
      S_ADJ_SIZE: begin
        ram_req.raddr = link_r[ADDR_W-1:0];
        state_nxt     = S_ADJ_LINK;
      end

      S_ADJ_LINK: begin
        ram_req.raddr = link_r[ADDR_W-1:0] + ADDR_W'(1);
        size_nxt      = size_r + ram_rdata + WORD_W'(HDR_WORDS);
        state_nxt     = S_MRG_SZ;
      end

      S_MRG_SZ: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_r[ADDR_W-1:0];
        ram_req.wdata = size_r;
        link_nxt      = alink;
        state_nxt     = S_MRG_LK;
      end

      S_MRG_LK: begin
        ram_req.we    = (cur_r < LINK_W'(LAST_ADDR));
        ram_req.waddr = cur_r[ADDR_W-1:0] + ADDR_W'(1);
        ram_req.wdata = WORD_W'(link_r);
        cur_nxt       = link_r;
        state_nxt     = (link_r == NULL_LINK) ? S_FINISH : S_RD_SIZE;
      end

      S_FINISH: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (heap_init) begin
      free_head_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
    end
    act_r    <= act_nxt;
    req_r    <= req_nxt;
    loc_r    <= loc_nxt;
    total_r  <= total_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    link_r   <= link_nxt;
    succ_r   <= succ_nxt;
    steps_r  <= steps_nxt;
    size_r   <= size_nxt;
    status_r <= status_nxt;
    paddr_r  <= paddr_nxt;
  end

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NULL_LINK)
    else $error("free list head beyond null link");

  a_walk_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_SIZE || state_r == S_RD_LINK || state_r == S_EVAL)
      |-> cur_r < NULL_LINK)
    else $error("walking a null node");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> steps_r <= STEP_W'(RAM_WORDS))
    else $error("walk step counter overran");

  a_nospace_reserve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && status_r == STAT_NO_SPACE) |-> act_r == ACT_RESERVE)
    else $error("no-space status on a non-reserve transaction");
`endif

endmodule

FILE: sv/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list heap allocator.
`timescale 1ns / 1ps

// Word-addressed heap allocator with the free list kept inside a 1024 x 17 bit
// RAM (size word, then next-free link, per block; null link = 1024). Each request
// transaction gives exactly one response transaction. Reserve walks the list
// first-fit and takes a block whose payload is at least request + 2, splitting off
// the tail when larger; free pushes the block on the list head; coalesce walks the
// list once merging blocks with a list successor that sits directly after them.
// Sequence: the RAM has one read port, so every list node visited takes a size
// read, a link read and an evaluate step. Once a block is found, reserve writes the
// split tail header, the predecessor link and the block header; each coalesce merge
// reads the adjacent header and writes the merged one; free takes one write; and
// every transaction passes an accept step and a step that hands the result to the
// output register. Requests are handled one at a time; the output register lets a
// new request start while the previous response is still waiting. After reset,
// and after every write of heap_words, a clearing pass rewrites the RAM (one word
// a cycle) as a single free block at address 0; no request is accepted during it.
// heap_words is clamped to 4..1024.

module first_fit_free_list_allocator import ffa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  ffa_req_if.sink          in_req,
  ffa_rsp_if.source        out_rsp
);

  // heap size register and clearing sweep
  logic [CFG_W-1:0]  heap_words_r, heap_words_nxt;
  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [WORD_W-1:0] clr_wdata;

  // response register
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [PADDR_W-1:0] out_paddr_r, out_paddr_nxt;

  ffa_item_t         item;
  ffa_ram_req_t      walk_req;
  ffa_result_t       res;
  logic              item_ready;
  logic              res_take;
  logic              slot_free;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  always_comb begin
    heap_words_nxt = heap_words_r;
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (cfg_we) begin
      // clamp and restart the sweep
      if (cfg_wdata < CFG_W'(HEAP_MIN))       heap_words_nxt = CFG_W'(HEAP_MIN);
      else if (cfg_wdata > CFG_W'(RAM_WORDS)) heap_words_nxt = CFG_W'(RAM_WORDS);
      else                                    heap_words_nxt = cfg_wdata;
      clr_active_nxt = 1'b1;
      clr_cnt_nxt    = '0;
    end else if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      if (clr_cnt_r == ADDR_W'(LAST_ADDR)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  // word 0 = initial payload, word 1 = null link, all others zero
  always_comb begin
    if (clr_cnt_r == ADDR_W'(0))      clr_wdata = WORD_W'(heap_words_r - CFG_W'(HDR_WORDS));
    else if (clr_cnt_r == ADDR_W'(1)) clr_wdata = WORD_W'(NULL_LINK);
    else                              clr_wdata = '0;
  end

  assign ram_we    = clr_active_r ? 1'b1      : walk_req.we;
  assign ram_waddr = clr_active_r ? clr_cnt_r : walk_req.waddr;
  assign ram_wdata = clr_active_r ? clr_wdata : walk_req.wdata;

  ffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_WORDS)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_req.raddr),
    .rdata (ram_rdata)
  );

  assign item.action        = in_req.action;
  assign item.request_size  = in_req.request_size;
  assign item.free_location = in_req.free_location;
  assign in_req.ready       = item_ready && !clr_active_r;

  ffa_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .heap_init  (cfg_we),
    .item_valid (in_req.valid && !clr_active_r),
    .item_ready (item_ready),
    .item       (item),
    .ram_req    (walk_req),
    .ram_rdata  (ram_rdata),
    .res        (res),
    .res_take   (res_take)
  );

  // output register: free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign res_take  = res.valid && slot_free;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_paddr_nxt  = out_paddr_r;
    if (res_take) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res.status;
      out_paddr_nxt  = res.payload_address;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_words_r <= CFG_W'(RAM_WORDS);
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      heap_words_r <= heap_words_nxt;
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_paddr_r  <= out_paddr_nxt;
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.payload_address = out_paddr_r;

endmodule

FILE: tb/first_fit_free_list_allocator_tb.sv
// Self-checking testbench for the first-fit free-list heap allocator.
`timescale 1ns / 1ps

module first_fit_free_list_allocator_tb;
  import ffa_pkg::*;

  // Action code that the block must ignore (answers done, address 0).
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  // Predicted answer to one request transaction.
  typedef struct packed {
    logic               status;
    logic [PADDR_W-1:0] payload_address;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  ffa_req_if req_ch ();
  ffa_rsp_if rsp_ch ();

  first_fit_free_list_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow heap: our own copy of the RAM image, the list head and the managed
  // size. Sizes and links live in the same 17-bit words as in the block.
  // A link at or past RAM_WORDS means end of list.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] heap_img [RAM_WORDS];
  int unsigned       list_head;
  int unsigned       heap_len;

  answer_t           owed_answers [$];   // answers still to come, oldest first
  logic [PADDR_W-1:0] held_blocks [$];   // payload addresses currently reserved
  int                bad_answers = 0;

  bit                idle_on = 1'b1;     // random gaps on both channels
  int                stall_request = 0;  // long receiver hold-off, in cycles
  int                hold_left = 0;

  function automatic int unsigned img_size(input int unsigned a);
    return (a < RAM_WORDS) ? heap_img[a] : 0;
  endfunction

  // Link word of the header at a; anything off the end reads as null.
  function automatic int unsigned img_link(input int unsigned a);
    int unsigned v;
    if (a >= RAM_WORDS - 1) return RAM_WORDS;
    v = heap_img[a + 1];
    return (v >= RAM_WORDS) ? RAM_WORDS : v;
  endfunction

  // Writes past the RAM are lost, as in the block.
  function automatic void img_write(input int unsigned a, input int unsigned v);
    if (a < RAM_WORDS) heap_img[a] = WORD_W'(v);
  endfunction

  function automatic void img_format();
    foreach (heap_img[i]) heap_img[i] = '0;
    img_write(0, heap_len - HDR_WORDS);
    img_write(1, RAM_WORDS);
    list_head = 0;
  endfunction

  // First-fit walk. Split when the block is bigger than request + header,
  // unlink it whole when equal; the taken block keeps a null link.
  function automatic void model_reserve(input int unsigned req, output logic ok,
                                        output logic [PADDR_W-1:0] pa);
    int unsigned need, cur, prev, walked, succ, tail;
    need   = req + HDR_WORDS;
    cur    = (list_head >= RAM_WORDS) ? RAM_WORDS : list_head;
    prev   = RAM_WORDS;
    walked = 0;
    ok     = 1'b0;
    pa     = '0;
    while (cur != RAM_WORDS && img_size(cur) < need) begin
      walked++;
      if (walked > RAM_WORDS) return;   // list loops back on itself
      prev = cur;
      cur  = img_link(cur);
    end
    if (cur == RAM_WORDS) return;
    if (img_size(cur) > need) begin
      tail = cur + need;
      img_write(tail, img_size(cur) - need);
      img_write(tail + 1, img_link(cur));
      succ = (tail >= RAM_WORDS) ? RAM_WORDS : tail;
    end else begin
      succ = img_link(cur);
    end
    if (prev == RAM_WORDS) list_head = succ;
    else                   img_write(prev + 1, succ);
    img_write(cur, req);
    img_write(cur + 1, RAM_WORDS);
    ok = 1'b1;
    pa = PADDR_W'(cur + HDR_WORDS);   // wraps at the top of the RAM
  endfunction

  // LIFO push; addresses below the header size are ignored.
  function automatic void model_free(input int unsigned loc);
    int unsigned hdr;
    if (loc < HDR_WORDS) return;
    hdr = loc - HDR_WORDS;
    img_write(hdr + 1, list_head);
    list_head = hdr;
  endfunction

  // One pass along the list, merging with a list successor that sits
  // directly after the block in memory.
  function automatic void model_coalesce();
    int unsigned cur, nxt, adj, walked;
    cur    = (list_head >= RAM_WORDS) ? RAM_WORDS : list_head;
    walked = 0;
    while (cur != RAM_WORDS && img_link(cur) != RAM_WORDS) begin
      nxt = img_link(cur);
      adj = cur + img_size(cur) + HDR_WORDS;
      walked++;
      if (walked > RAM_WORDS) return;
      if (nxt == adj) begin
        img_write(cur, img_size(cur) + img_size(adj) + HDR_WORDS);
        img_write(cur + 1, img_link(adj));
      end
      cur = img_link(cur);
    end
  endfunction

  function automatic answer_t predict_answer(input logic [ACT_W-1:0] act,
                                             input int unsigned rsz,
                                             input int unsigned loc);
    answer_t a;
    logic    ok;
    a.status          = STAT_DONE;
    a.payload_address = '0;
    case (act)
      ACT_RESERVE: begin
        model_reserve(rsz, ok, a.payload_address);
        if (!ok) a.status = STAT_NO_SPACE;
      end
      ACT_FREE:     model_free(loc);
      ACT_COALESCE: model_coalesce();
      default: ;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. valid is left high after a transaction so back-to-back
  // requests never lower and raise it in the same step; whoever lets time
  // pass without a new request (a gap, settle) lowers it first.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [REQ_W-1:0] rsz,
                         input logic [LOC_W-1:0] loc, output answer_t got);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.request_size  <= rsz;
    req_ch.free_location <= loc;
    do @(posedge clk); while (!req_ch.ready);
    got = predict_answer(act, rsz, loc);
    owed_answers.push_back(got);
  endtask

  // Stop offering and wait for every owed answer.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (owed_answers.size() != 0);
  endtask

  // Only written with the block idle; it then runs its clearing pass and
  // holds ready low until the heap is one free block again.
  task automatic write_heap_words(input logic [CFG_W-1:0] words);
    int unsigned w;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= words;
    @(posedge clk);
    cfg_we    <= 1'b0;
    w = words;
    if (w < HEAP_MIN)  w = HEAP_MIN;
    if (w > RAM_WORDS) w = RAM_WORDS;
    heap_len = w;
    img_format();
    held_blocks.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Response side: checks each accepted transaction against the oldest owed
  // answer, then decides ready for the next edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_side
    answer_t seen, want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      seen.status          = rsp_ch.status;
      seen.payload_address = rsp_ch.payload_address;
      if (owed_answers.size() == 0) begin
        bad_answers++;
        $display("%0t: unexpected answer: status %0b address %0d", $time,
                 seen.status, seen.payload_address);
      end else begin
        want = owed_answers.pop_front();
        if (seen.status !== want.status) begin
          bad_answers++;
          $display("%0t: status mismatch: expected %0b actual %0b", $time,
                   want.status, seen.status);
        end
        if (seen.payload_address !== want.payload_address) begin
          bad_answers++;
          $display("%0t: address mismatch: expected %0d actual %0d", $time,
                   want.payload_address, seen.payload_address);
        end
      end
    end
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_left    = $urandom_range(0, 8);   // start a random hold-off burst
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Exact take, split, empty list, request extremes, frees below two,
  // the spare action and a merge by coalesce, all from the reset heap.
  task automatic test_directed_basics();
    answer_t got;
    send_op(ACT_RESERVE, 10'd1020, 10'd0, got);    // whole block, list empties
    send_op(ACT_RESERVE, 10'd0, 10'd0, got);       // nothing left
    send_op(ACT_FREE, 10'd0, 10'd2, got);
    send_op(ACT_RESERVE, 10'd0, 10'd0, got);       // split, tail at 2
    send_op(ACT_RESERVE, 10'd1023, 10'd0, got);
    send_op(ACT_RESERVE, 10'd1022, 10'd0, got);
    send_op(ACT_FREE, 10'd0, 10'd0, got);
    send_op(ACT_FREE, 10'd0, 10'd1, got);
    send_op(ACT_SPARE, 10'h3FF, 10'h3FF, got);
    send_op(ACT_RESERVE, 10'd5, 10'd0, got);
    send_op(ACT_FREE, 10'd0, 10'd4, got);          // sits right before the tail
    send_op(ACT_COALESCE, 10'd0, 10'd0, got);
    send_op(ACT_RESERVE, 10'd1016, 10'd0, got);    // exact fit of merged block
  endtask

  // Size register below and above its range.
  task automatic test_heap_limits();
    answer_t got;
    write_heap_words(11'd0);                       // clamps to four words
    send_op(ACT_RESERVE, 10'd0, 10'd0, got);
    send_op(ACT_RESERVE, 10'd0, 10'd0, got);
    write_heap_words(11'h7FF);                     // clamps to the full RAM
  endtask

  // Fake header over an old link word gives a block that claims more than
  // the RAM holds: the split tail lands past the end and the grant wraps.
  task automatic test_past_ram();
    answer_t got;
    send_op(ACT_RESERVE, 10'd1000, 10'd0, got);
    send_op(ACT_FREE, 10'd0, 10'd1005, got);
    send_op(ACT_RESERVE, 10'd1000, 10'd0, got);
    send_op(ACT_FREE, 10'd0, 10'd1005, got);
    send_op(ACT_RESERVE, 10'd17, 10'd0, got);      // tail header at 1022
    send_op(ACT_RESERVE, 10'd0, 10'd0, got);       // grant wraps to 0
  endtask

  // Double free makes a self loop; both walks must give up.
  task automatic test_looping_list();
    answer_t got;
    write_heap_words(11'd64);
    send_op(ACT_RESERVE, 10'd4, 10'd0, got);
    send_op(ACT_FREE, 10'd0, 10'd2, got);
    send_op(ACT_FREE, 10'd0, 10'd2, got);
    send_op(ACT_RESERVE, 10'd10, 10'd0, got);
    send_op(ACT_COALESCE, 10'd0, 10'd0, got);
  endtask

  // Well-formed traffic: reserves of mostly small sizes, frees of blocks
  // actually held, the odd coalesce, and a little harmless noise.
  task automatic run_traffic(input int n, input int unsigned big_req);
    answer_t          got;
    int               pick, idx, r;
    logic [REQ_W-1:0] rsz;
    logic [LOC_W-1:0] loc;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      rsz  = REQ_W'($urandom);
      loc  = LOC_W'($urandom);
      if (pick < 45 || (held_blocks.size() == 0 && pick < 85)) begin
        r = $urandom_range(0, 9);
        if (r < 7)      rsz = REQ_W'($urandom_range(0, 24));
        else if (r < 9) rsz = REQ_W'($urandom_range(0, big_req));
        send_op(ACT_RESERVE, rsz, loc, got);
        if (got.status == STAT_DONE) held_blocks.push_back(got.payload_address);
      end else if (pick < 85) begin
        idx = $urandom_range(0, held_blocks.size() - 1);
        loc = held_blocks[idx];
        held_blocks.delete(idx);
        send_op(ACT_FREE, rsz, loc, got);
      end else if (pick < 95) begin
        send_op(ACT_COALESCE, rsz, loc, got);
      end else if (pick < 98) begin
        send_op(ACT_SPARE, rsz, loc, got);
      end else begin
        send_op(ACT_FREE, rsz, LOC_W'($urandom_range(0, 1)), got);
      end
    end
  endtask

  task automatic test_random_traffic();
    write_heap_words(11'd1024);
    run_traffic(480, 300);
    write_heap_words(11'd12);
    run_traffic(70, 12);
    write_heap_words(11'($urandom_range(5, 60)));
    run_traffic(80, 40);
    write_heap_words(11'($urandom_range(100, 900)));
    run_traffic(250, 200);
  endtask

  // Receiver stops for a long stretch while requests keep coming, so the
  // block fills and holds off its input; later the sender drains fully.
  task automatic test_backpressure();
    write_heap_words(11'd512);
    stall_request = 400;
    run_traffic(60, 100);
    settle();
    run_traffic(60, 100);
  endtask

  // Broken sequences: double frees and frees of arbitrary addresses corrupt
  // the list, giving loops, garbage sizes and headers near the RAM top.
  task automatic test_corrupt_frees();
    answer_t got;
    int      pick;
    write_heap_words(11'd96);
    repeat (100) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_op(ACT_RESERVE, REQ_W'($urandom_range(0, 40)), LOC_W'($urandom), got);
      else if (pick < 8)
        send_op(ACT_FREE, REQ_W'($urandom), LOC_W'($urandom), got);
      else
        send_op(ACT_COALESCE, REQ_W'($urandom), LOC_W'($urandom), got);
    end
  endtask

  // Last stretch with both sides at full rate.
  task automatic test_quiet_finish();
    idle_on = 1'b0;
    write_heap_words(11'd1024);
    run_traffic(230, 300);
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.action        = '0;
    req_ch.request_size  = '0;
    req_ch.free_location = '0;
    heap_len             = RAM_WORDS;
    img_format();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_heap_limits();
    test_past_ram();
    test_looping_list();
    test_random_traffic();
    test_backpressure();
    test_corrupt_frees();
    test_quiet_finish();

    settle();
    repeat (40) @(posedge clk);
    if (bad_answers == 0)
      $display("first_fit_free_list_allocator test passed");
    else
      $display("first_fit_free_list_allocator test failed");
    $finish;
  end

  // Watchdog, far beyond a run where every walk goes the full RAM length.
  initial begin
    #240_000_000;
    $display("first_fit_free_list_allocator test failed");
    $finish;
  end

endmodule
